/* hdl/bdrs_pkg.sv */
// Shared types and constants for the block decomposed range sum core.
`default_nettype none

package bdrs_pkg;

	// default sizes
	localparam int ELEMENTS_DEF   = 4096;
	localparam int BLOCK_SIZE_DEF = 64;

	// request / result field widths
	localparam int IDX_W = 12;
	localparam int VAL_W = 32;
	localparam int SUM_W = 64;

	// request kind code
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_WRD,
		ST_WUPD,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic wr_read;
		logic wr_commit;
		logic walk_step;
		logic clr_step;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_write_ok;
		logic in_empty;
		logic div_last;
		logic walk_last;
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

/* hdl/block_decomposed_range_sum_core.sv */
// Top level of the block decomposed range sum core (point write, range-sum query).
// Usage:
//  - Request channel: in_valid/in_stall with kind, first_index, last_index, value.
//    kind 0 writes value at first_index (no result); kind 1 asks for the sum over
//    first_index..last_index inclusive. last_index is clamped to ELEMENTS-1, an
//    empty range returns 0, a write past the end is dropped.
//  - Result channel: out_valid/out_stall with the 64-bit signed range_sum.
//  - One request is worked on at a time. A write goes from the accept through a
//    split of the index into block and offset (quotient by a reciprocal multiply,
//    then remainder), then a read and a write, to the next accept.
//  - A query also takes the accept and the split, then one memory read per walk
//    step: up to BLOCK_SIZE-1 edge elements on each side plus one read per whole
//    block, at most 188 reads at default sizes. After a drain step range_sum is
//    loaded once the output register is free. An empty range skips the split and
//    the walk. The single read port of each memory, one read per cycle, paces it.
//  - After reset the core runs a clearing pass over all ELEMENTS addresses that
//    zeroes both memories; in_stall stays high during it.
//  - The result sits in an output register; while the receiver stalls, the next
//    request is still taken and worked on, and only its own result waits.
`default_nettype none

module block_decomposed_range_sum_core #(
	parameter int ELEMENTS   = bdrs_pkg::ELEMENTS_DEF,
	parameter int BLOCK_SIZE = bdrs_pkg::BLOCK_SIZE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              kind,
	input  wire logic [bdrs_pkg::IDX_W-1:0]        first_index,
	input  wire logic [bdrs_pkg::IDX_W-1:0]        last_index,
	input  wire logic signed [bdrs_pkg::VAL_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [bdrs_pkg::SUM_W-1:0]      range_sum
);

	bdrs_pkg::cmd_t cmd;
	bdrs_pkg::sts_t sts;

	// sequencing: clear pass, index split, walk/update, result hand-off
	bdrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.kind      (kind),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// memories, index split, walk counters and accumulator
	bdrs_dp #(
		.ELEMENTS   (ELEMENTS),
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.first_index (first_index),
		.last_index  (last_index),
		.value       (value),
		.cmd         (cmd),
		.sts         (sts),
		.range_sum   (range_sum)
	);

endmodule

`default_nettype wire

/* hdl/bdrs_dp.sv */
// Datapath: element and block-sum memories, index split, walk counters, accumulator.
`default_nettype none

module bdrs_dp #(
	parameter int ELEMENTS   = bdrs_pkg::ELEMENTS_DEF,
	parameter int BLOCK_SIZE = bdrs_pkg::BLOCK_SIZE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [bdrs_pkg::IDX_W-1:0]       first_index,
	input  wire logic [bdrs_pkg::IDX_W-1:0]       last_index,
	input  wire logic signed [bdrs_pkg::VAL_W-1:0] value,
	input  wire bdrs_pkg::cmd_t                   cmd,
	output bdrs_pkg::sts_t                        sts,
	output logic signed [bdrs_pkg::SUM_W-1:0]     range_sum
);

	localparam int NB  = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int AW  = $clog2(ELEMENTS);
	localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
	localparam int OW  = $clog2(BLOCK_SIZE);
	localparam int RW  = OW + 1;
	localparam int SW  = bdrs_pkg::VAL_W + OW;
	localparam int CW  = ((AW > bdrs_pkg::IDX_W) ? AW : bdrs_pkg::IDX_W) + 1;
	localparam int DCW = 1;
	localparam int VW  = bdrs_pkg::VAL_W;
	localparam int XW  = bdrs_pkg::SUM_W;
	// reciprocal of BLOCK_SIZE, exact for every CW-bit index
	localparam int SH  = CW + OW;
	localparam int MW  = CW + 2;
	localparam int PW  = CW + MW;

	localparam logic [CW-1:0]  E_C    = CW'(ELEMENTS);
	localparam logic [CW-1:0]  E_M1   = CW'(ELEMENTS - 1);
	localparam logic [CW-1:0]  B_C    = CW'(BLOCK_SIZE);
	localparam logic [CW-1:0]  B_M1   = CW'(BLOCK_SIZE - 1);
	localparam logic [RW-1:0]  B_RM1  = RW'(BLOCK_SIZE - 1);
	localparam logic [DCW-1:0] DIV_END = DCW'(1);
	localparam logic [AW:0]    NB_C   = (AW + 1)'(NB);
	localparam logic [AW-1:0]  CLR_END = AW'(ELEMENTS - 1);
	localparam logic [MW-1:0]  RCP    = MW'(((longint'(1) << SH) + longint'(BLOCK_SIZE) - 1)
		/ longint'(BLOCK_SIZE));

	// memories
	logic [VW-1:0] elem_mem [ELEMENTS];
	logic [SW-1:0] bsum_mem [NB];

	// request registers
	logic [CW-1:0]  lo_q, hi_q, i_q;
	logic [VW-1:0]  val_q;
	logic [CW-1:0]  dvd_q;   // index, then quotient = block index
	logic [RW-1:0]  rem_q;   // offset in block
	logic [DCW-1:0] div_cnt_q;
	logic [AW-1:0]  clr_cnt_q;
	logic [VW-1:0]  elem_rd_q;
	logic [SW-1:0]  bsum_rd_q;
	logic           rd_elem_s1, rd_bsum_s1;
	logic [XW-1:0]  acc_q;
	logic [XW-1:0]  sum_q;

	// request decode
	logic [CW-1:0] first_x, last_x, hi_sat;
	always_comb begin
		first_x = CW'(first_index);
		last_x  = CW'(last_index);
		hi_sat  = (last_x > E_M1) ? E_M1 : last_x;
	end

	// index split: quotient by reciprocal multiply, then remainder
	logic [PW-1:0] quo_prod;
	logic [CW-1:0] quo, rem_full;
	always_comb begin
		quo_prod = PW'(dvd_q) * PW'(RCP);
		quo      = CW'(quo_prod >> SH);
		rem_full = lo_q - (dvd_q * B_C);
	end

	// walk step
	logic [CW-1:0] i_nxt;
	logic          use_blk, rem_wrap, blk_adv;
	always_comb begin
		use_blk  = (rem_q == '0) && ((i_q + B_M1) <= hi_q);
		rem_wrap = rem_q == B_RM1;
		blk_adv  = use_blk | rem_wrap;
		i_nxt    = use_blk ? (i_q + B_C) : (i_q + CW'(1));
	end

	always_comb begin
		sts.in_write_ok = first_x < E_C;
		sts.in_empty    = first_x > hi_sat;
		sts.div_last    = div_cnt_q == DIV_END;
		sts.walk_last   = i_nxt > hi_q;
		sts.clr_last    = clr_cnt_q == CLR_END;
	end

	// memory port control
	logic          elem_re, elem_we, bsum_re, bsum_we, clr_in_blk;
	logic [AW-1:0] elem_raddr, elem_waddr;
	logic [BW-1:0] bsum_waddr;
	logic [VW-1:0] elem_wdata;
	logic [SW-1:0] bsum_wdata, bsum_new;
	always_comb begin
		clr_in_blk = {1'b0, clr_cnt_q} < NB_C;
		elem_re    = (cmd.walk_step & ~use_blk) | cmd.wr_read;
		bsum_re    = (cmd.walk_step & use_blk) | cmd.wr_read;
		elem_raddr = cmd.walk_step ? i_q[AW-1:0] : lo_q[AW-1:0];
		elem_we    = cmd.clr_step | cmd.wr_commit;
		elem_waddr = cmd.clr_step ? clr_cnt_q : lo_q[AW-1:0];
		elem_wdata = cmd.clr_step ? '0 : val_q;
		bsum_new   = bsum_rd_q + {{(SW-VW){val_q[VW-1]}}, val_q}
			- {{(SW-VW){elem_rd_q[VW-1]}}, elem_rd_q};
		bsum_we    = (cmd.clr_step & clr_in_blk) | cmd.wr_commit;
		bsum_waddr = cmd.clr_step ? clr_cnt_q[BW-1:0] : dvd_q[BW-1:0];
		bsum_wdata = cmd.clr_step ? '0 : bsum_new;
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_waddr] <= elem_wdata;
		end
		if (elem_re) begin
			elem_rd_q <= elem_mem[elem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (bsum_we) begin
			bsum_mem[bsum_waddr] <= bsum_wdata;
		end
		if (bsum_re) begin
			bsum_rd_q <= bsum_mem[dvd_q[BW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			div_cnt_q  <= '0;
			rd_elem_s1 <= 1'b0;
			rd_bsum_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			rd_elem_s1 <= cmd.walk_step & ~use_blk;
			rd_bsum_s1 <= cmd.walk_step & use_blk;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q  <= first_x;
			hi_q  <= hi_sat;
			i_q   <= first_x;
			val_q <= value;
			dvd_q <= first_x;
			rem_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.div_step) begin
				if (div_cnt_q == DIV_END) begin
					rem_q <= RW'(rem_full);
				end else begin
					dvd_q <= quo;
				end
			end else if (cmd.walk_step) begin
				i_q <= i_nxt;
				if (blk_adv) begin
					dvd_q <= dvd_q + CW'(1);
				end
				if (!use_blk) begin
					rem_q <= rem_wrap ? '0 : rem_q + RW'(1);
				end
			end
			if (rd_elem_s1) begin
				acc_q <= acc_q + {{(XW-VW){elem_rd_q[VW-1]}}, elem_rd_q};
			end else if (rd_bsum_s1) begin
				acc_q <= acc_q + {{(XW-SW){bsum_rd_q[SW-1]}}, bsum_rd_q};
			end
		end
		if (cmd.out_load) begin
			sum_q <= acc_q;
		end
	end

	assign range_sum = sum_q;

endmodule

`default_nettype wire

/* hdl/bdrs_ctrl.sv */
// Controller: request sequencing state machine and result valid flag.
`default_nettype none

module bdrs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           kind,
	input  wire logic           out_stall,
	input  wire bdrs_pkg::sts_t sts,
	output bdrs_pkg::cmd_t      cmd,
	output logic                in_stall,
	output logic                out_valid
);

	bdrs_pkg::state_t state_q, state_nxt;
	logic             query_q, query_nxt;
	logic             out_valid_q;
	logic             slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdrs_pkg::ST_CLEAR;
			query_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			query_q     <= query_nxt;
			out_valid_q <= cmd.out_load | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		slot_free = ~out_valid_q | ~out_stall;
		state_nxt = state_q;
		query_nxt = query_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			bdrs_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_nxt = bdrs_pkg::ST_IDLE;
				end
			end
			bdrs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					query_nxt = kind == bdrs_pkg::KIND_QUERY;
					if (kind == bdrs_pkg::KIND_QUERY) begin
						state_nxt = sts.in_empty ? bdrs_pkg::ST_FINISH : bdrs_pkg::ST_DIV;
					end else if (sts.in_write_ok) begin
						state_nxt = bdrs_pkg::ST_DIV;
					end
				end
			end
			bdrs_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = query_q ? bdrs_pkg::ST_WALK : bdrs_pkg::ST_WRD;
				end
			end
			bdrs_pkg::ST_WRD: begin
				cmd.wr_read = 1'b1;
				state_nxt   = bdrs_pkg::ST_WUPD;
			end
			bdrs_pkg::ST_WUPD: begin
				cmd.wr_commit = 1'b1;
				state_nxt     = bdrs_pkg::ST_IDLE;
			end
			bdrs_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_nxt = bdrs_pkg::ST_DRAIN;
				end
			end
			bdrs_pkg::ST_DRAIN: begin
				state_nxt = bdrs_pkg::ST_FINISH;
			end
			bdrs_pkg::ST_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = bdrs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bdrs_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* dv/block_decomposed_range_sum_core_tb.sv */
// Self-checking testbench for the block decomposed range sum core: point writes and range-sum queries.

module block_decomposed_range_sum_core_tb;

	localparam int IDX_W = bdrs_pkg::IDX_W;
	localparam int VAL_W = bdrs_pkg::VAL_W;
	localparam int SUM_W = bdrs_pkg::SUM_W;

	localparam int NUM_ELEMS   = bdrs_pkg::ELEMENTS_DEF;
	localparam int BLK         = bdrs_pkg::BLOCK_SIZE_DEF;
	localparam int NUM_BLOCKS  = (NUM_ELEMS + BLK - 1) / BLK;
	localparam int CYCLE_LIMIT = 1_500_000;
	// worst query walks up to 188 reads; leave margin for the tail
	localparam int TAIL_CYCLES = 300;
	localparam int LONG_HOLD   = 3000;

	localparam logic KIND_QUERY = bdrs_pkg::KIND_QUERY;
	localparam logic KIND_WRITE = ~bdrs_pkg::KIND_QUERY;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic [IDX_W-1:0]        IDX_TOP = IDX_W'(NUM_ELEMS - 1);

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     kind;
	logic [IDX_W-1:0]         first_index;
	logic [IDX_W-1:0]         last_index;
	logic signed [VAL_W-1:0]  value;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [SUM_W-1:0]  range_sum;

	// shadow copy of the element array and per-block sums
	logic signed [VAL_W-1:0]  shadow_elems [NUM_ELEMS];
	logic signed [SUM_W-1:0]  shadow_block_sums [NUM_BLOCKS];
	logic signed [SUM_W-1:0]  expected_sums [$];

	int error_count;
	int cycle_count;
	// idling knobs, flipped per test phase
	bit tx_random_idle;
	bit rx_random_idle;
	// long receiver hold-off; loaded by a test, counted down by the stall driver
	int rx_hold_left;

	block_decomposed_range_sum_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.first_index (first_index),
		.last_index  (last_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.range_sum   (range_sum)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic void clear_shadow();
		foreach (shadow_elems[i])
			shadow_elems[i] = '0;
		foreach (shadow_block_sums[i])
			shadow_block_sums[i] = '0;
	endfunction

	// Replace one element and move its block sum by the difference.
	// Indices at or past the array end are dropped.
	function automatic void apply_write(input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] v);
		logic signed [SUM_W-1:0] delta;
		if (idx < NUM_ELEMS) begin
			delta = SUM_W'(v);
			delta = delta - SUM_W'(shadow_elems[idx]);
			shadow_block_sums[idx / BLK] += delta;
			shadow_elems[idx] = v;
		end
	endfunction

	// Inclusive range sum: whole blocks from the block sums, ragged edges
	// element by element. Right end saturates to the last element, and an
	// empty range gives zero.
	function automatic logic signed [SUM_W-1:0] predict_range_sum(
		input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
		logic signed [SUM_W-1:0] acc;
		int unsigned pos;
		int unsigned top;
		acc = '0;
		top = 32'(hi);
		if (top >= NUM_ELEMS)
			top = NUM_ELEMS - 1;
		if (32'(lo) > top)
			return '0;
		pos = 32'(lo);
		while (pos <= top) begin
			if ((pos % BLK) == 0 && pos + BLK - 1 <= top) begin
				acc += shadow_block_sums[pos / BLK];
				pos += BLK;
			end else begin
				acc += SUM_W'(shadow_elems[pos]);
				pos++;
			end
		end
		return acc;
	endfunction

	// ---------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------

	// Entered at a rising edge. Holds the request until it is taken, updates
	// the shadow state, then draws the gap before the next request. With a
	// zero gap in_valid stays high so the next request follows back to back.
	task automatic send_request(input logic k, input logic [IDX_W-1:0] fi,
		input logic [IDX_W-1:0] li, input logic signed [VAL_W-1:0] v);
		int gap;
		in_valid    <= 1'b1;
		kind        <= k;
		first_index <= fi;
		last_index  <= li;
		value       <= v;
		do
			@(posedge clk);
		while (in_stall);
		if (k == KIND_QUERY)
			expected_sums.push_back(predict_range_sum(fi, li));
		else
			apply_write(fi, v);
		gap = tx_random_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid before any pause so a taken request is not offered again.
	task automatic sender_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results_drained();
		while (expected_sums.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Random request. Mostly well-formed traffic with random content, plus
	// shapes that hit block alignment, short spans, empty ranges and the
	// value extremes.
	task automatic send_random_request(input int write_pct);
		logic                    k;
		logic signed [VAL_W-1:0] v;
		int                      lo;
		int                      hi;
		int                      swap;
		k  = ($urandom_range(0, 99) < write_pct) ? KIND_WRITE : KIND_QUERY;
		lo = $urandom_range(0, NUM_ELEMS - 1);
		hi = $urandom_range(0, NUM_ELEMS - 1);
		v  = $urandom;
		case ($urandom_range(0, 11))
			0: v = VAL_MAX;
			1: v = VAL_MIN;
			2: begin
				// block-aligned span of whole blocks
				lo = $urandom_range(0, NUM_BLOCKS - 1) * BLK;
				hi = lo + $urandom_range(1, 8) * BLK - 1;
			end
			3: begin
				// short span, often inside one block
				hi = lo + $urandom_range(0, BLK + 2);
			end
			4: begin
				// left at or above right, so mostly empty
				if (lo < hi) begin
					swap = lo;
					lo   = hi;
					hi   = swap;
				end
			end
			5: begin
				// start on a block edge, random end
				lo = $urandom_range(0, NUM_BLOCKS - 1) * BLK;
			end
			6: v = $urandom_range(0, 15) - 8;
			default: begin
				// keep ranges well formed so most queries walk blocks
				if (lo > hi) begin
					swap = lo;
					lo   = hi;
					hi   = swap;
				end
			end
		endcase
		if (hi > NUM_ELEMS - 1)
			hi = NUM_ELEMS - 1;
		send_request(k, lo[IDX_W-1:0], hi[IDX_W-1:0], v);
	endtask

	// ---------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what,
		input logic signed [SUM_W-1:0] want, input logic signed [SUM_W-1:0] got);
		$display("MISMATCH at cycle %0d: %s, expected %0d got %0d",
			cycle_count, what, want, got);
		error_count++;
	endtask

	// Stall driver. After each taken result it may draw a short hold, and now
	// and then it stalls with nothing pending so holds land on every phase.
	// A test can load rx_hold_left to hold off for a long stretch.
	initial begin : result_stall_driver
		int gap_left;
		gap_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_random_idle && out_valid && !out_stall)
				gap_left = $urandom_range(0, 11);
			else if (gap_left > 0)
				gap_left--;
			else if (rx_random_idle && $urandom_range(0, 15) == 0)
				gap_left = $urandom_range(1, 11);
			if (rx_hold_left > 0)
				rx_hold_left--;
			out_stall <= (gap_left > 0) || (rx_hold_left > 0);
		end
	end

	// Compare every taken result with the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		logic signed [SUM_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_sums.size() == 0) begin
				report_mismatch("result with no query outstanding", '0, range_sum);
			end else begin
				want = expected_sums.pop_front();
				if (range_sum !== want)
					report_mismatch("range_sum", want, range_sum);
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Freshly cleared store must read zero everywhere.
	task automatic test_cleared_store();
		send_request(KIND_QUERY, 12'd0, IDX_TOP, VAL_MAX);
		send_request(KIND_QUERY, 12'd0, 12'd0, 32'sd0);
		send_request(KIND_QUERY, IDX_TOP, IDX_TOP, VAL_MIN);
	endtask

	// Field extremes, block edges, overwrite, empty ranges.
	task automatic test_directed_edges();
		send_request(KIND_WRITE, 12'd0, IDX_TOP, VAL_MAX);
		send_request(KIND_WRITE, IDX_TOP, 12'd0, VAL_MIN);
		send_request(KIND_WRITE, 12'd63, 12'd5, -32'sd1);
		send_request(KIND_WRITE, 12'd64, 12'hfff, 32'sd1);
		send_request(KIND_WRITE, 12'd127, 12'h555, VAL_MAX);
		send_request(KIND_WRITE, 12'd128, 12'haaa, VAL_MIN);
		send_request(KIND_QUERY, 12'd0, IDX_TOP, 32'sh5555_5555);
		send_request(KIND_QUERY, 12'd0, 12'd63, 32'shaaaa_aaaa);
		send_request(KIND_QUERY, 12'd63, 12'd64, 32'sd0);
		send_request(KIND_QUERY, 12'd64, 12'd127, 32'sd0);
		send_request(KIND_QUERY, 12'd1, IDX_TOP - 12'd1, 32'sd0);
		send_request(KIND_QUERY, IDX_TOP, IDX_TOP, 32'sd0);
		// left above right: empty
		send_request(KIND_QUERY, 12'd10, 12'd3, 32'sd0);
		send_request(KIND_QUERY, IDX_TOP, 12'd0, 32'sd0);
		// overwrite moves the block sum by the difference only
		send_request(KIND_WRITE, 12'd0, 12'd0, 32'sd5);
		send_request(KIND_WRITE, 12'd64, 12'd0, VAL_MIN);
		send_request(KIND_QUERY, 12'd0, 12'd127, 32'sd0);
		send_request(KIND_QUERY, 12'd0, 12'd0, 32'sd0);
		send_request(KIND_QUERY, 12'd64, 12'd191, 32'sd0);
	endtask

	// Fill whole blocks with extreme values to push the sum into its upper
	// bits, then query across them from both aligned and ragged ends.
	task automatic test_heavy_blocks();
		for (int i = 0; i < BLK; i++)
			send_request(KIND_WRITE, 12'(10 * BLK + i), 12'(i), VAL_MAX);
		for (int i = 0; i < BLK; i++)
			send_request(KIND_WRITE, 12'(20 * BLK + i), 12'(i), VAL_MIN);
		send_request(KIND_QUERY, 12'(10 * BLK), 12'(11 * BLK - 1), 32'sd0);
		send_request(KIND_QUERY, 12'(20 * BLK), 12'(21 * BLK - 1), 32'sd0);
		send_request(KIND_QUERY, 12'(10 * BLK + 1), 12'(21 * BLK - 2), 32'sd0);
		send_request(KIND_QUERY, 12'(15 * BLK), IDX_TOP, 32'sd0);
		send_request(KIND_QUERY, 12'd0, 12'(11 * BLK), 32'sd0);
	endtask

	task automatic test_random_traffic(input int count);
		tx_random_idle = 1'b1;
		rx_random_idle = 1'b1;
		repeat (count) send_random_request(50);
	endtask

	// Back to back on both sides: no idling at all.
	task automatic test_back_to_back(input int count);
		tx_random_idle = 1'b0;
		rx_random_idle = 1'b0;
		repeat (count) send_random_request(50);
	endtask

	// Receiver holds off while queries keep coming: the output register
	// fills, the next query finishes behind it, and the input stalls.
	task automatic test_output_hold_off();
		tx_random_idle = 1'b0;
		rx_random_idle = 1'b0;
		rx_hold_left   = LONG_HOLD;
		repeat (30) send_random_request(0);
	endtask

	// Sender stops until every outstanding result is back, then resumes.
	task automatic test_pause_until_drained();
		tx_random_idle = 1'b1;
		rx_random_idle = 1'b1;
		repeat (40) send_random_request(40);
		sender_idle();
		wait_results_drained();
		repeat (40) send_random_request(40);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------

	initial begin
		error_count    = 0;
		tx_random_idle = 1'b0;
		rx_random_idle = 1'b0;
		rx_hold_left   = 0;
		clear_shadow();
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= KIND_WRITE;
		first_index <= '0;
		last_index  <= '0;
		value       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the core clears both memories first; in_stall covers that pass
		test_cleared_store();
		test_directed_edges();
		test_heavy_blocks();
		test_random_traffic(560);
		test_back_to_back(300);
		test_output_hold_off();
		test_pause_until_drained();
		test_random_traffic(300);

		sender_idle();
		while (expected_sums.size() != 0)
			@(posedge clk);
		// writes carry no result; let any late stray output show up
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_sums.size() == 0)
			$display("block_decomposed_range_sum_core_tb OK");
		else
			$display("block_decomposed_range_sum_core_tb NOT OK");
		$finish;
	end

	// Watchdog: ends a hung run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TIMEOUT after %0d cycles, %0d results outstanding",
			cycle_count, expected_sums.size());
		$display("block_decomposed_range_sum_core_tb NOT OK");
		$finish;
	end

endmodule

/* files.f */
hdl/bdrs_pkg.sv
hdl/bdrs_dp.sv
hdl/bdrs_ctrl.sv
hdl/block_decomposed_range_sum_core.sv
dv/block_decomposed_range_sum_core_tb.sv
